// File: hw/rtl/ic0d_pkg.sv
// Package for the IC0 diagonal builder: payload structs, sizes, control structs.
// No dependencies.
package ic0d_pkg;

  localparam int MaxLine  = 64;
  localparam int MaxSlice = 4096;
  localparam int JAw      = $clog2(MaxLine);
  localparam int KAw      = $clog2(MaxSlice);
  localparam int RowW     = 18;
  localparam int SizeW    = 7;
  localparam int SizeMax  = 64;

  // Row index, slice size and row total; the total is kept at the full
  // product width since 64 * 64 * 64 rows do not fit in RowW bits.
  typedef logic [RowW-1:0] row_t;
  typedef logic [KAw:0]    slice_t;
  typedef logic [RowW+1:0] total_t;

  localparam logic [1:0] CfgISize = 2'd0;
  localparam logic [1:0] CfgJSize = 2'd1;
  localparam logic [1:0] CfgKSize = 2'd2;

  // Term select codes.
  localparam logic [1:0] SelI = 2'd0;
  localparam logic [1:0] SelJ = 2'd1;
  localparam logic [1:0] SelK = 2'd2;

  typedef struct packed {
    logic signed [31:0] diag_coef;
    logic signed [31:0] i_coupling;
    logic signed [31:0] j_coupling;
    logic signed [31:0] k_coupling;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] precond_diag;
    logic               row_last;
    logic               breakdown;
  } out_item_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic       load;       // capture the input transaction, start the row positions
    logic       pivot;      // form the pivot from the read terms
    logic       div_start;  // begin a term division
    logic [1:0] div_sel;    // which coupling: SelI, SelJ or SelK
    logic       div_store;  // write the finished term
    logic       out_load;   // place the result in the output register
  } dp_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic mod_busy;
    logic div_busy;
    logic brk;
  } dp_sts_t;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] s);
    logic [SizeW-1:0] v;
    v = s;
    if (s == '0) v = SizeW'(1);
    else if (s > SizeW'(SizeMax)) v = SizeW'(SizeMax);
    return v;
  endfunction

endpackage

// File: hw/rtl/ic0d_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ic0d_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/ic0d_div.sv
// Radix-2 restoring divider: 64-bit dividend by 32-bit positive divisor,
// quotient saturated to 0x7FFFFFFF. Depends on nothing.
module ic0d_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quot
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; cnt_nxt = cnt_r;
    shifted = {rem_r[31:0], q_r[63]};
    trial = shifted - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; d_nxt = divisor; cnt_nxt = 7'd64;
    end else if (cnt_r != 7'd0) begin
      cnt_nxt = cnt_r - 7'd1;
      if (!trial[32]) begin
        rem_nxt = trial; q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted; q_nxt = {q_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
  end

  assign busy = start || (cnt_r != 7'd0);
  assign quot = (q_r[63:31] != '0) ? 32'h7FFF_FFFF : q_r[31:0];
endmodule

// File: hw/rtl/ic0d_datapath.sv
// Datapath: row indexing, term stores, pivot, shared divider, output register.
// Depends on ic0d_pkg, ic0d_ram, ic0d_div.
module ic0d_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [6:0]          cfg_wdata,
  input  ic0d_pkg::in_item_t  in_item,
  input  ic0d_pkg::dp_cmd_t   cmd,
  output ic0d_pkg::dp_sts_t   sts,
  output ic0d_pkg::out_item_t out_item
);
  logic [ic0d_pkg::SizeW-1:0] i_size_r, j_size_r, k_size_r;
  ic0d_pkg::row_t             row_r, row_nxt;
  logic signed [31:0]         iterm_r;
  ic0d_pkg::in_item_t         item_r;
  ic0d_pkg::row_t             r_r;
  ic0d_pkg::row_t             rsh_r;
  ic0d_pkg::slice_t           slice_r;
  logic [ic0d_pkg::SizeW-1:0] ei_r;
  ic0d_pkg::total_t           total_r;
  logic [ic0d_pkg::JAw-1:0]   ji_r;
  logic [ic0d_pkg::KAw-1:0]   ki_r;
  logic [4:0]                 mcnt_r;
  logic signed [31:0]         m_r;
  logic                       brk_r;
  ic0d_pkg::out_item_t        out_r;

  // Size clamping and products (registered into the row context).
  logic [ic0d_pkg::SizeW-1:0] ei, ej, ek;
  ic0d_pkg::slice_t slice;
  ic0d_pkg::total_t total;
  ic0d_pkg::row_t   r;
  always_comb begin
    ei = ic0d_pkg::clamp_size(i_size_r);
    ej = ic0d_pkg::clamp_size(j_size_r);
    ek = ic0d_pkg::clamp_size(k_size_r);
    slice = ic0d_pkg::slice_t'(ei * ej);
    total = ic0d_pkg::total_t'(slice) * ic0d_pkg::total_t'(ek);
    r = (ic0d_pkg::total_t'(row_r) >= total) ? '0 : row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_size_r <= 7'd1; j_size_r <= 7'd1; k_size_r <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ic0d_pkg::CfgISize: i_size_r <= cfg_wdata;
        ic0d_pkg::CfgJSize: j_size_r <= cfg_wdata;
        ic0d_pkg::CfgKSize: k_size_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Line and slice positions r % ei and r % slice: restoring remainder,
  // one bit of r per cycle, starting after load.
  logic [ic0d_pkg::JAw:0] jtry, jsub;
  logic [ic0d_pkg::KAw:0] ktry, ksub;
  always_comb begin
    jtry = {ji_r, rsh_r[ic0d_pkg::RowW-1]};
    ktry = {ki_r, rsh_r[ic0d_pkg::RowW-1]};
    jsub = jtry - ei_r;
    ksub = ktry - slice_r;
  end

  // Term stores, read at the row's positions.
  logic [31:0] jrd, krd, term_q;
  logic        div_busy;
  logic [31:0] a_sel;
  logic [31:0] a_mag;
  logic [63:0] sq;
  logic        jwe, kwe;
  assign jwe = cmd.div_store && (cmd.div_sel == ic0d_pkg::SelJ);
  assign kwe = cmd.div_store && (cmd.div_sel == ic0d_pkg::SelK);

  ic0d_ram #(.Width(32), .Depth(ic0d_pkg::MaxLine)) u_jram (
    .clk, .we(jwe), .waddr(ji_r), .wdata(brk_r ? 32'd0 : term_q),
    .raddr(ji_r), .rdata(jrd));
  ic0d_ram #(.Width(32), .Depth(ic0d_pkg::MaxSlice)) u_kram (
    .clk, .we(kwe), .waddr(ki_r), .wdata(brk_r ? 32'd0 : term_q),
    .raddr(ki_r), .rdata(krd));

  // Pivot: a0 - terms, exact in 35 bits, saturated.
  logic signed [34:0] m_wide;
  always_comb begin
    m_wide = 35'(item_r.diag_coef);
    if (r_r >= ic0d_pkg::row_t'(1)) m_wide = m_wide - 35'(iterm_r);
    if (r_r >= ic0d_pkg::row_t'(ei_r)) m_wide = m_wide - 35'($signed({1'b0, jrd}));
    if (r_r >= ic0d_pkg::row_t'(slice_r)) m_wide = m_wide - 35'($signed({1'b0, krd}));
  end

  // Selected coupling, squared for the divider.
  always_comb begin
    unique case (cmd.div_sel)
      ic0d_pkg::SelI: a_sel = item_r.i_coupling;
      ic0d_pkg::SelJ: a_sel = item_r.j_coupling;
      default: a_sel = item_r.k_coupling;
    endcase
    a_mag = a_sel[31] ? (32'd0 - a_sel) : a_sel;
    sq = 64'(a_mag) * 64'(a_mag);
  end

  ic0d_div u_div (
    .clk, .rst_n, .start(cmd.div_start), .dividend(sq),
    .divisor(m_r), .busy(div_busy), .quot(term_q));

  always_comb begin
    row_nxt = row_r;
    if (cmd.load) begin
      row_nxt = (ic0d_pkg::total_t'(r) + ic0d_pkg::total_t'(1) >= total) ? '0 :
                r + ic0d_pkg::row_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0; iterm_r <= '0; mcnt_r <= '0;
    end else begin
      row_r <= row_nxt;
      if (cmd.load) mcnt_r <= 5'(ic0d_pkg::RowW);
      else if (mcnt_r != '0) mcnt_r <= mcnt_r - 5'd1;
      if (cmd.div_store && cmd.div_sel == ic0d_pkg::SelI) iterm_r <= brk_r ? '0 : term_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item; r_r <= r; slice_r <= slice; ei_r <= ei; total_r <= total;
      rsh_r <= r; ji_r <= '0; ki_r <= '0;
    end else if (mcnt_r != '0) begin
      rsh_r <= {rsh_r[ic0d_pkg::RowW-2:0], 1'b0};
      ji_r <= (jtry >= ei_r) ? jsub[ic0d_pkg::JAw-1:0] : jtry[ic0d_pkg::JAw-1:0];
      ki_r <= (ktry >= slice_r) ? ksub[ic0d_pkg::KAw-1:0] : ktry[ic0d_pkg::KAw-1:0];
    end
    if (cmd.pivot) begin
      if (m_wide > 35'sh0_7FFF_FFFF) m_r <= 32'h7FFF_FFFF;
      else if (m_wide < -35'sh0_8000_0000) m_r <= 32'h8000_0000;
      else m_r <= m_wide[31:0];
      brk_r <= (m_wide <= 0);
    end
    if (cmd.out_load) begin
      out_r.precond_diag <= m_r;
      out_r.row_last <= (ic0d_pkg::total_t'(r_r) == total_r - ic0d_pkg::total_t'(1));
      out_r.breakdown <= brk_r;
    end
  end

  assign sts.mod_busy = (mcnt_r != '0);
  assign sts.div_busy = div_busy;
  assign sts.brk = brk_r;
  assign out_item = out_r;
endmodule

// File: hw/rtl/ic0d_ctrl.sv
// Controller: sequences load, row positions, pivot, up to 3 divisions, result handoff.
// Depends on ic0d_pkg.
module ic0d_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ic0d_pkg::dp_sts_t sts,
  output ic0d_pkg::dp_cmd_t cmd
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOD   = 7'b0000010,
    S_READ  = 7'b0000100,
    S_PIV   = 7'b0001000,
    S_SQ    = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t st_r, st_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic ov_r, ov_nxt;

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    st_nxt = st_r; sel_nxt = sel_r; ov_nxt = ov_r;
    cmd = '0;
    cmd.div_sel = sel_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; st_nxt = S_MOD; end
      S_MOD: if (!sts.mod_busy) st_nxt = S_READ;
      S_READ: st_nxt = S_PIV;
      S_PIV: begin cmd.pivot = 1'b1; sel_nxt = ic0d_pkg::SelI; st_nxt = S_SQ; end
      S_SQ: if (sts.brk) begin
          cmd.div_store = 1'b1;
          if (sel_r == ic0d_pkg::SelK) st_nxt = S_OUT; else sel_nxt = sel_r + 2'd1;
        end else begin
          cmd.div_start = 1'b1; st_nxt = S_DIV;
        end
      S_DIV: if (!sts.div_busy) begin
          cmd.div_store = 1'b1;
          if (sel_r == ic0d_pkg::SelK) st_nxt = S_OUT;
          else begin sel_nxt = sel_r + 2'd1; st_nxt = S_SQ; end
        end
      S_OUT: if (!ov_r || !out_stall) begin
          cmd.out_load = 1'b1; ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; sel_r <= ic0d_pkg::SelI; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; sel_r <= sel_nxt; ov_r <= ov_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("state not one-hot");
  a_store_sel: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_store |-> sel_r <= ic0d_pkg::SelK) else $error("bad term select");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> st_r == S_IDLE) else $error("load outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("stalled result dropped");
endmodule

// File: hw/rtl/ic0_diagonal_7pt_builder_unit.sv
// IC0 diagonal builder for a 7-point stencil: one row in, one diagonal out.
// One row is in work at a time: the next row is accepted only once the
// controller is back in idle after placing the result in the output register.
// The work goes to finding the row's line and slice positions (one remainder
// bit per cycle), the term read and pivot states, and three term steps
// (set-up, 64-step radix-2 division of the squared coupling by the new pivot,
// store) on a shared divider, which sets the pace. A breakdown row skips the
// divisions. The output register holds a finished result while the next row
// is accepted; a result not yet taken delays only the next one's handoff.
// Depends on ic0d_pkg, ic0d_ctrl, ic0d_datapath.
module ic0_diagonal_7pt_builder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [6:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  ic0d_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ic0d_pkg::out_item_t out_data
);
  ic0d_pkg::dp_cmd_t cmd;
  ic0d_pkg::dp_sts_t sts;

  ic0d_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd);

  ic0d_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata, .in_item(in_data),
    .cmd, .sts, .out_item(out_data));
endmodule
